>>> src/llsp_pkg.sv
`default_nettype none

package llsp_pkg;

	// Table geometry
	localparam int MAX_SERVERS = 16;
	localparam int JOB_BITS    = 8;
	localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int PROD_W      = 2 * JOB_BITS;
	localparam logic [JOB_BITS-1:0] JOB_MAX = {JOB_BITS{1'b1}};

	// Operation codes
	localparam logic OP_PICK   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// Server status codes
	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_ONLINE  = 2'd1;
	localparam logic [1:0] ST_OFFLINE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_SERVER_COUNT = 2'd0;
	localparam logic [1:0] CFG_ENABLED_MASK = 2'd1;
	localparam logic [1:0] CFG_INIT_LIMIT   = 2'd2;

	typedef struct packed {
		logic load;
		logic pref_chk;
		logic sweep;
		logic fin_upd;
		logic fin_pick;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
	} stat_t;

	// Clamp a reported signed count into the job range; zero or below gives zero
	function automatic logic [JOB_BITS-1:0] sat_job(input logic signed [8:0] v);
		logic [31:0] u;
		u = 32'(unsigned'(v));
		if (v[8] || (v == 9'sd0))
			return '0;
		else if (u > 32'(JOB_MAX))
			return JOB_MAX;
		else
			return JOB_BITS'(u);
	endfunction

	// Clamp an unsigned register value into the job range
	function automatic logic [JOB_BITS-1:0] sat_lim(input logic [7:0] v);
		logic [31:0] u;
		u = 32'(v);
		if (u > 32'(JOB_MAX))
			return JOB_MAX;
		else
			return JOB_BITS'(u);
	endfunction

endpackage

`default_nettype wire

>>> src/llsp_ctrl.sv
`default_nettype none

module llsp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           op,
	input  wire llsp_pkg::stat_t st,
	output llsp_pkg::cmd_t      cmd,
	output logic                busy,
	output logic                done
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UPD   = 3'd1;
	localparam logic [2:0] S_PREF  = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_LAST  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (op == llsp_pkg::OP_UPDATE) ? S_UPD : S_PREF;
				end
			end
			S_UPD: begin
				cmd.fin_upd = 1'b1;
				state_d     = S_IDLE;
			end
			S_PREF: begin
				cmd.pref_chk = 1'b1;
				state_d      = S_SWEEP;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (st.sweep_last)
					state_d = S_LAST;
			end
			S_LAST: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin_pick = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.fin_upd | cmd.fin_pick;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

`ifndef SYNTH
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == S_UPD || $past(state_q) == S_FIN))
		else $error("result strobe without a finishing state");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_UPD || state_q == S_PREF))
		else $error("accepted request did not start work");
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && st.sweep_last) |=> (state_q == S_LAST))
		else $error("sweep did not close after the last entry");
`endif

endmodule

`default_nettype wire

>>> src/llsp_dp.sv
`default_nettype none

module llsp_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_addr,
	input  wire logic [15:0]          cfg_data,
	input  wire logic                 has_preferred,
	input  wire logic [3:0]           preferred_index,
	input  wire logic [3:0]           target_index,
	input  wire logic [1:0]           new_status,
	input  wire logic signed [8:0]    running_jobs,
	input  wire logic signed [8:0]    job_limit,
	input  wire llsp_pkg::cmd_t       cmd,
	output llsp_pkg::stat_t           st,
	output logic                      found,
	output logic [3:0]                chosen_index
);

	localparam int JB = llsp_pkg::JOB_BITS;
	localparam int IW = llsp_pkg::IDX_W;
	localparam int PW = llsp_pkg::PROD_W;
	localparam int NS = llsp_pkg::MAX_SERVERS;

	// Configuration; the initial limit lives only in the table it loads
	logic [4:0]  count_q;
	logic [15:0] mask_q;

	// Server table
	logic [1:0]    status_q  [NS];
	logic [JB-1:0] running_q [NS];
	logic [JB-1:0] limit_q   [NS];

	// Latched request
	logic              req_pref_q;
	logic [3:0]        req_pidx_q;
	logic [3:0]        req_tidx_q;
	logic [1:0]        req_status_q;
	logic signed [8:0] req_run_q;
	logic signed [8:0] req_lim_q;

	// Sweep and best candidates
	logic [IW-1:0] cnt_q;
	logic          pref_ok_q;
	logic          on_have_q, unk_have_q;
	logic [IW-1:0] on_idx_q, unk_idx_q;
	logic [JB-1:0] on_num_q, on_den_q, unk_num_q, unk_den_q;
	logic          on_s1, unk_s1;
	logic [IW-1:0] idx_s1;
	logic [JB-1:0] num_s1, den_s1;

	logic          found_q;
	logic [3:0]    chosen_q;

	logic [7:0]    n8;
	logic [IW-1:0] rd_idx;
	logic [1:0]    rd_status;
	logic [JB-1:0] rd_run, rd_lim;
	logic [63:0]   mask_ext;
	logic          rd_avail;
	logic          tgt_ok;
	logic          sel_have;
	logic [JB-1:0] sel_num, sel_den;
	logic [PW-1:0] lhs, rhs;
	logic          take;

	assign n8 = (8'(count_q) > 8'(NS)) ? 8'(NS) : 8'(count_q);

	// One read port: the preferred entry during the check, else the sweep entry
	assign rd_idx    = cmd.pref_chk ? IW'(req_pidx_q) : cnt_q;
	assign rd_status = status_q[rd_idx];
	assign rd_run    = running_q[rd_idx];
	assign rd_lim    = limit_q[rd_idx];
	assign mask_ext  = 64'(mask_q);
	assign rd_avail  = mask_ext[6'(rd_idx)] && (rd_status != llsp_pkg::ST_OFFLINE) &&
		((rd_lim == '0) || (rd_run < rd_lim));

	assign tgt_ok = (8'(req_tidx_q) < n8);
	assign st.sweep_last = (cnt_q == IW'(NS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd16;
			mask_q  <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_addr)
				llsp_pkg::CFG_SERVER_COUNT: count_q <= cfg_data[4:0];
				llsp_pkg::CFG_ENABLED_MASK: mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				status_q[i]  <= llsp_pkg::ST_UNKNOWN;
				running_q[i] <= '0;
				limit_q[i]   <= '0;
			end
		end else if (cfg_we && (cfg_addr == llsp_pkg::CFG_INIT_LIMIT)) begin
			for (int i = 0; i < NS; i++)
				limit_q[i] <= llsp_pkg::sat_lim(cfg_data[7:0]);
		end else if (cmd.fin_upd && tgt_ok) begin
			status_q[IW'(req_tidx_q)]  <= req_status_q;
			running_q[IW'(req_tidx_q)] <= llsp_pkg::sat_job(req_run_q);
			if (!req_lim_q[8] && (req_lim_q != 9'sd0))
				limit_q[IW'(req_tidx_q)] <= llsp_pkg::sat_job(req_lim_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_pref_q   <= has_preferred;
			req_pidx_q   <= preferred_index;
			req_tidx_q   <= target_index;
			req_status_q <= new_status;
			req_run_q    <= running_jobs;
			req_lim_q    <= job_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			on_s1 <= 1'b0;
			unk_s1 <= 1'b0;
		end else begin
			if (cmd.pref_chk)
				cnt_q <= '0;
			else if (cmd.sweep)
				cnt_q <= cnt_q + IW'(1);
			on_s1  <= cmd.sweep && (8'(cnt_q) < n8) && rd_avail &&
				(rd_status == llsp_pkg::ST_ONLINE);
			unk_s1 <= cmd.sweep && (8'(cnt_q) < n8) && rd_avail &&
				(rd_status == llsp_pkg::ST_UNKNOWN);
		end
	end

	// Load as a fraction; an unlimited server sits at zero
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		num_s1 <= (rd_lim == '0) ? '0 : rd_run;
		den_s1 <= (rd_lim == '0) ? JB'(1) : rd_lim;
	end

	// Compare the candidate against the best of its own class only
	assign sel_have = on_s1 ? on_have_q : unk_have_q;
	assign sel_num  = on_s1 ? on_num_q : unk_num_q;
	assign sel_den  = on_s1 ? on_den_q : unk_den_q;
	assign lhs      = PW'(num_s1) * PW'(sel_den);
	assign rhs      = PW'(sel_num) * PW'(den_s1);
	assign take     = !sel_have || (lhs < rhs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_ok_q  <= 1'b0;
			on_have_q  <= 1'b0;
			unk_have_q <= 1'b0;
		end else if (cmd.pref_chk) begin
			pref_ok_q  <= req_pref_q && (8'(req_pidx_q) < n8) && rd_avail &&
				((rd_status == llsp_pkg::ST_ONLINE) || (rd_status == llsp_pkg::ST_UNKNOWN));
			on_have_q  <= 1'b0;
			unk_have_q <= 1'b0;
		end else begin
			if (on_s1 && take)
				on_have_q <= 1'b1;
			if (unk_s1 && take)
				unk_have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (on_s1 && take) begin
			on_idx_q <= idx_s1;
			on_num_q <= num_s1;
			on_den_q <= den_s1;
		end
		if (unk_s1 && take) begin
			unk_idx_q <= idx_s1;
			unk_num_q <= num_s1;
			unk_den_q <= den_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_upd) begin
			found_q  <= tgt_ok;
			chosen_q <= 4'd0;
		end else if (cmd.fin_pick) begin
			found_q <= pref_ok_q | on_have_q | unk_have_q;
			if (pref_ok_q)
				chosen_q <= req_pidx_q;
			else if (on_have_q)
				chosen_q <= 4'(on_idx_q);
			else if (unk_have_q)
				chosen_q <= 4'(unk_idx_q);
			else
				chosen_q <= 4'd0;
		end
	end

	assign found        = found_q;
	assign chosen_index = chosen_q;

`ifndef SYNTH
	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_pick |=> (found_q || chosen_q == 4'd0))
		else $error("pick without a server must answer index zero");
`endif

endmodule

`default_nettype wire

>>> src/least_loaded_server_picker_core.sv
`default_nettype none

// Least loaded server picker.
// Request channel: drive the fields and raise start; the request is taken at
// the rising edge where start is high and busy is low. op selects a pick
// (choose a server for a job) or an update (write one server's status, running
// count and limit). Each request gives one result: found and chosen_index are
// shown for exactly one cycle with done high and are taken at the end of it.
// Flow: an update writes its target entry and then strobes its result; a pick checks
// the preferred entry, then walks all 16 table entries through one shared
// read port and a single cross-multiply comparator (one entry per cycle, the
// comparison working on registered read data) before it strobes its result.
// busy drops during the result cycle, so a new request can be taken then.
// Configuration: cfg_we, cfg_addr, cfg_data write a register; write only while
// idle. Writing the initial job limit reloads every limit.
// Reset (arst_n low) sets count 16, all servers enabled, all entries unknown
// with zero jobs and an unlimited limit. The receiver cannot stall results.

module least_loaded_server_picker_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_addr,
	input  wire logic [15:0]       cfg_data,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              op,
	input  wire logic              has_preferred,
	input  wire logic [3:0]        preferred_index,
	input  wire logic [3:0]        target_index,
	input  wire logic [1:0]        new_status,
	input  wire logic signed [8:0] running_jobs,
	input  wire logic signed [8:0] job_limit,
	output logic                   done,
	output logic                   found,
	output logic [3:0]             chosen_index
);

	llsp_pkg::cmd_t  cmd;
	llsp_pkg::stat_t st;

	// Sequencer: accept, then update, or check the preferred entry and sweep; finish, strobe
	llsp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Table, configuration, best-candidate tracking and result registers
	llsp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_data        (cfg_data),
		.has_preferred   (has_preferred),
		.preferred_index (preferred_index),
		.target_index    (target_index),
		.new_status      (new_status),
		.running_jobs    (running_jobs),
		.job_limit       (job_limit),
		.cmd             (cmd),
		.st              (st),
		.found           (found),
		.chosen_index    (chosen_index)
	);

endmodule

`default_nettype wire
